// ===== rtl/core/zdf_pkg.sv =====
// ----------------------------------------------------------------------------
// zdf_pkg: shared types, constants and microcode for the multimode svf
// Holds register indexes, mode codes, the control word layout and the
// read-only step program that drives the filter datapath.
// ----------------------------------------------------------------------------
package zdf_pkg;

  // fixed widths of state and coefficients
  localparam int ACC_W     = 32;
  localparam int COEF_W    = 32;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W    = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORM = 2'd3;

  // filter modes
  localparam logic [MODE_W-1:0] MODE_LP      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HP      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BP      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UBP     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_NOTCH   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ALLPASS = 3'd5;
  localparam logic [MODE_W-1:0] MODE_PEAK    = 3'd6;

  // coefficient reset values
  localparam logic [COEF_W-1:0] FREQ_RST = 32'd0;
  localparam logic [COEF_W-1:0] DAMP_RST = 32'd379625062;
  localparam logic [COEF_W-1:0] NORM_RST = 32'd268435456;

  // multiplier signal operand
  typedef enum logic [1:0] {
    OPA_Z1  = 2'd0,
    OPA_NUM = 2'd1,
    OPA_HP  = 2'd2,
    OPA_BP  = 2'd3
  } opa_t;

  // multiplier coefficient operand
  typedef enum logic [1:0] {
    OPC_DAMP = 2'd0,
    OPC_FREQ = 2'd1,
    OPC_NORM = 2'd2
  } opc_t;

  // where the registered product goes
  typedef enum logic [2:0] {
    DST_NONE = 3'd0,
    DST_T1   = 3'd1,
    DST_NUM  = 3'd2,
    DST_HP   = 3'd3,
    DST_BP   = 3'd4,
    DST_LP   = 3'd5,
    DST_UBP  = 3'd6
  } dst_t;

  // conditional jump kinds
  typedef enum logic {
    JMP_NONE   = 1'b0,
    JMP_NO_UBP = 1'b1
  } jmp_t;

  typedef struct packed {
    opa_t              opa;
    opc_t              opc;
    logic              mul_en;
    dst_t              dst;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
    logic              last;
  } ctl_word_t;

  localparam logic [STEP_W-1:0] STEP_FIRST = 4'd0;
  localparam logic [STEP_W-1:0] STEP_LAST  = 4'd10;

  // step program: a product launched in one step is written back in the next, unless the jump skips step 9
  function automatic ctl_word_t ucode(input logic [STEP_W-1:0] step);
    ctl_word_t w;
    w = '{opa: OPA_Z1, opc: OPC_DAMP, mul_en: 1'b0, dst: DST_NONE,
          jmp: JMP_NONE, target: STEP_FIRST, last: 1'b0};
    case (step)
      4'd0: begin
        w.opa = OPA_Z1;  w.opc = OPC_DAMP; w.mul_en = 1'b1;
      end
      4'd1: begin
        w.opa = OPA_Z1;  w.opc = OPC_FREQ; w.mul_en = 1'b1; w.dst = DST_T1;
      end
      4'd2: begin
        w.dst = DST_NUM;
      end
      4'd3: begin
        w.opa = OPA_NUM; w.opc = OPC_NORM; w.mul_en = 1'b1;
      end
      4'd4: begin
        w.dst = DST_HP;
      end
      4'd5: begin
        w.opa = OPA_HP;  w.opc = OPC_FREQ; w.mul_en = 1'b1;
      end
      4'd6: begin
        w.dst = DST_BP;
      end
      4'd7: begin
        w.opa = OPA_BP;  w.opc = OPC_FREQ; w.mul_en = 1'b1;
      end
      4'd8: begin
        w.opa = OPA_BP;  w.opc = OPC_DAMP; w.mul_en = 1'b1; w.dst = DST_LP;
        w.jmp = JMP_NO_UBP; w.target = STEP_LAST;
      end
      4'd9: begin
        w.dst = DST_UBP;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/zdf_dp.sv =====
// ----------------------------------------------------------------------------
// zdf_dp: filter datapath
// One shared rounding multiplier with a registered product, the integrator
// states, the intermediate signal registers and the mode output select.
// ----------------------------------------------------------------------------
module zdf_dp
  import zdf_pkg::*;
#(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          run,
  input  ctl_word_t                     ctl,
  input  logic                          commit,
  input  logic [MODE_W-1:0]             mode,
  input  logic [COEF_W-1:0]             freq,
  input  logic [COEF_W-1:0]             damp,
  input  logic [COEF_W-1:0]             norm,
  output logic signed [SAMPLE_BITS-1:0] y
);

  localparam int MUL_W = ACC_W + COEF_W + 1;
  localparam int PW    = MUL_W - COEF_FRAC_BITS;
  localparam int SW    = PW + 2;

  localparam logic signed [MUL_W-1:0] RND    = MUL_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [SW-1:0]    ACC_HI = (SW'(1) <<< (ACC_W - 1)) - SW'(1);
  localparam logic signed [SW-1:0]    ACC_LO = -ACC_HI - SW'(1);
  localparam logic signed [SW-1:0]    SMP_HI = (SW'(1) <<< (SAMPLE_BITS - 1)) - SW'(1);
  localparam logic signed [SW-1:0]    SMP_LO = -SMP_HI - SW'(1);

  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [ACC_W-1:0]       z1_r, z2_r;
  logic signed [ACC_W-1:0]       num_r, hp_r, bp_r, lp_r;
  logic signed [PW-1:0]          prod_r, t1_r, ghp_r, gbp_r, ubp_r;

  logic signed [ACC_W-1:0]  op_a;
  logic [COEF_W-1:0]        op_c;
  logic signed [MUL_W-1:0]  prod_full;
  logic signed [MUL_W-1:0]  prod_rnd;
  logic signed [PW-1:0]     prod_nxt;
  logic signed [SW-1:0]     num_sum, bp_sum, lp_sum, z1_sum, z2_sum, y_sum;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    c = (v > ACC_HI) ? ACC_HI : ((v < ACC_LO) ? ACC_LO : v);
    return c[ACC_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    c = (v > SMP_HI) ? SMP_HI : ((v < SMP_LO) ? SMP_LO : v);
    return c[SAMPLE_BITS-1:0];
  endfunction

  // operand selection
  always_comb begin
    case (ctl.opa)
      OPA_Z1:  op_a = z1_r;
      OPA_NUM: op_a = num_r;
      OPA_HP:  op_a = hp_r;
      OPA_BP:  op_a = bp_r;
      default: op_a = z1_r;
    endcase
    case (ctl.opc)
      OPC_DAMP: op_c = damp;
      OPC_FREQ: op_c = freq;
      OPC_NORM: op_c = norm;
      default:  op_c = damp;
    endcase
  end

  // signed by unsigned product, round half up, drop the fraction
  assign prod_full = op_a * $signed({1'b0, op_c});
  assign prod_rnd  = prod_full + RND;
  assign prod_nxt  = PW'(prod_rnd >>> COEF_FRAC_BITS);

  // write-back sums
  assign num_sum = SW'(x_r) - SW'(t1_r) - SW'(prod_r) - SW'(z2_r);
  assign bp_sum  = SW'(prod_r) + SW'(z1_r);
  assign lp_sum  = SW'(prod_r) + SW'(z2_r);
  assign z1_sum  = SW'(ghp_r) + SW'(bp_r);
  assign z2_sum  = SW'(gbp_r) + SW'(lp_r);

  // product register and intermediates
  always_ff @(posedge clk) begin
    if (load) begin
      x_r <= sample;
    end
    if (run && ctl.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (run) begin
      case (ctl.dst)
        DST_T1:  t1_r  <= prod_r;
        DST_NUM: num_r <= sat_acc(num_sum);
        DST_HP:  hp_r  <= sat_acc(SW'(prod_r));
        DST_BP: begin
          ghp_r <= prod_r;
          bp_r  <= sat_acc(bp_sum);
        end
        DST_LP: begin
          gbp_r <= prod_r;
          lp_r  <= sat_acc(lp_sum);
        end
        DST_UBP: ubp_r <= prod_r;
        default: ;
      endcase
    end
  end

  // integrator states
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z1_r <= '0;
      z2_r <= '0;
    end else if (commit) begin
      z1_r <= sat_acc(z1_sum);
      z2_r <= sat_acc(z2_sum);
    end
  end

  // mode output select
  always_comb begin
    case (mode)
      MODE_LP:      y_sum = SW'(lp_r);
      MODE_HP:      y_sum = SW'(hp_r);
      MODE_BP:      y_sum = SW'(bp_r);
      MODE_UBP:     y_sum = SW'(ubp_r);
      MODE_NOTCH:   y_sum = SW'(x_r) - SW'(ubp_r);
      MODE_ALLPASS: y_sum = SW'(x_r) - (SW'(ubp_r) <<< 1);
      MODE_PEAK:    y_sum = SW'(lp_r) - SW'(hp_r);
      default:      y_sum = '0;
    endcase
  end

  assign y = sat_smp(y_sum);

endmodule

// ===== rtl/core/zdf_svf_multimode_filter.sv =====
// ----------------------------------------------------------------------------
// zdf_svf_multimode_filter: two-pole trapezoidal state-variable filter
// Each accepted sample runs the step program; the damped bandpass write-back is
// skipped in modes other than unity bandpass, notch and allpass.
// A new sample is taken only once the previous result is issued, as the step
// program shares one 32x33 multiplier across the six products of a sample.
// Reset: synchronous active low; clears integrators, coefficients to defaults.
// ----------------------------------------------------------------------------
module zdf_svf_multimode_filter
  import zdf_pkg::*;
#(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [COEF_W-1:0]             cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } seq_state_t;

  seq_state_t st_r, st_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [MODE_W-1:0] mode_r;
  logic [COEF_W-1:0] freq_r, damp_r, norm_r;
  logic              out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic signed [SAMPLE_BITS-1:0] y;
  ctl_word_t         ctl;
  logic              in_beat, fin_go, run, skip_ubp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LP;
      freq_r <= FREQ_RST;
      damp_r <= DAMP_RST;
      norm_r <= NORM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE: mode_r <= cfg_wdata[MODE_W-1:0];
        REG_FREQ: freq_r <= cfg_wdata;
        REG_DAMP: damp_r <= cfg_wdata;
        REG_NORM: norm_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // microcode fetch and sequencing
  assign ctl      = ucode(step_r);
  assign in_ready = (st_r == S_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign run      = (st_r == S_RUN);
  assign fin_go   = run && ctl.last && (!out_valid_r || out_ready);

  always_comb begin
    skip_ubp = !(mode_r inside {MODE_UBP, MODE_NOTCH, MODE_ALLPASS});
    st_nxt   = st_r;
    step_nxt = step_r;
    case (st_r)
      S_IDLE: begin
        step_nxt = STEP_FIRST;
        if (in_valid) begin
          st_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (ctl.last) begin
          if (fin_go) begin
            st_nxt   = S_IDLE;
            step_nxt = STEP_FIRST;
          end
        end else if (ctl.jmp == JMP_NO_UBP && skip_ubp) begin
          step_nxt = ctl.target;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      default: begin
        st_nxt   = S_IDLE;
        step_nxt = STEP_FIRST;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      step_r <= STEP_FIRST;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
    end
  end

  // datapath
  zdf_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (in_beat),
    .sample (in_sample_in),
    .run    (run),
    .ctl    (ctl),
    .commit (fin_go),
    .mode   (mode_r),
    .freq   (freq_r),
    .damp   (damp_r),
    .norm   (norm_r),
    .y      (y)
  );

  // output register, one result beat per sample
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_sample_r <= y;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // checks
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_LAST)
    else $error("step counter ran past the program");

  a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_IDLE |-> step_r == STEP_FIRST)
    else $error("step counter not parked while idle");

  a_beat_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> st_r == S_RUN && step_r == STEP_FIRST)
    else $error("accepted sample did not start the program");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(run && ctl.last))
    else $error("result raised outside the final step");

endmodule
